// ----- design/spdtmr_pkg.sv -----
`default_nettype none

package spdtmr_pkg;

    // Fixed speed thresholds, centi-mph
    localparam logic [15:0] STOP_SPEED   = 16'd100;   // 1 mph
    localparam logic [15:0] MOVING_SPEED = 16'd1000;  // 10 mph

    // Register indexes on the configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_ENABLED  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AGE_LIMIT_MS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_FLOOR     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HDOP_LIMIT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_CEILING  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SPEED   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RUN_TIMEOUT_MS = 3'd6;
    localparam int unsigned CFG_DATA_W = 32;

    // Timer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // Configuration registers
    typedef struct packed {
        logic        block_enabled;
        logic [15:0] age_limit_ms;
        logic [15:0] stop_floor;
        logic [13:0] hdop_limit;
        logic [15:0] speed_ceiling;
        logic [15:0] target_speed;
        logic [31:0] run_timeout_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        block_enabled:  1'b0,
        age_limit_ms:   16'd2000,
        stop_floor:     16'd80,
        hdop_limit:     14'd400,
        speed_ceiling:  16'd20000,
        target_speed:   16'd6000,
        run_timeout_ms: 32'd60000
    };

    // Tracker state carried between updates
    typedef struct packed {
        logic [15:0] held_speed;
        logic [15:0] peak_speed;
        logic        peak_rearm;
        phase_t      timer_phase;
        logic [31:0] run_start;
        logic [31:0] run_elapsed;
        logic [31:0] previous_run;
        logic        fix_held;
        logic [31:0] fix_search_start;
        logic [31:0] fix_time;
    } state_t;

    localparam state_t STATE_RESET = '{
        held_speed:       16'd0,
        peak_speed:       16'd0,
        peak_rearm:       1'b0,
        timer_phase:      PH_IDLE,
        run_start:        32'd0,
        run_elapsed:      32'd0,
        previous_run:     32'd0,
        fix_held:         1'b0,
        fix_search_start: 32'd0,
        fix_time:         32'd0
    };

    // Input word
    typedef struct packed {
        logic [31:0] now_ms;
        logic        fix_valid;
        logic [31:0] fix_age_ms;
        logic [15:0] speed_centi_mph;
        logic [13:0] hdop_centi;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [15:0] shown_speed;
        logic [15:0] max_speed;
        logic [1:0]  run_phase;
        logic [31:0] run_time_ms;
        logic [31:0] last_run_ms;
        logic        run_finished;
        logic        run_timed_out;
        logic        have_fix;
        logic        fix_acquired;
        logic [31:0] fix_duration_ms;
    } out_word_t;

endpackage

`default_nettype wire

// ----- design/spdtmr_update.sv -----
`default_nettype none

// One receiver update applied to the tracker state: next state and result word.
module spdtmr_update (
    input  var spdtmr_pkg::cfg_t      cfg,
    input  var spdtmr_pkg::state_t    state_cur,
    input  var spdtmr_pkg::in_word_t  in_word,
    output var spdtmr_pkg::state_t    state_new,
    output var spdtmr_pkg::out_word_t out_word
);

    spdtmr_pkg::state_t st;
    logic        fresh;
    logic        good_hdop;
    logic [15:0] spd;
    logic        finished;
    logic        timed_out;
    logic        acquired;

    always_comb begin
        st        = state_cur;
        finished  = 1'b0;
        timed_out = 1'b0;
        acquired  = 1'b0;
        fresh     = in_word.fix_valid &&
                    (in_word.fix_age_ms < {16'd0, cfg.age_limit_ms});
        good_hdop = in_word.hdop_centi < cfg.hdop_limit;
        // low-speed floor
        spd       = (in_word.speed_centi_mph < cfg.stop_floor) ? 16'd0
                                                               : in_word.speed_centi_mph;

        if (cfg.block_enabled) begin
            if (fresh) begin
                st.held_speed = spd;

                // time to first fix
                if (!st.fix_held) begin
                    st.fix_time = in_word.now_ms - st.fix_search_start;
                    st.fix_held = 1'b1;
                    acquired    = 1'b1;
                end

                if (good_hdop) begin
                    // peak speed with re-arm after a stop
                    if (spd > st.peak_speed && spd < cfg.speed_ceiling) begin
                        st.peak_speed = spd;
                    end
                    if (spd < spdtmr_pkg::STOP_SPEED) begin
                        st.peak_rearm = 1'b1;
                    end
                    if (spd > spdtmr_pkg::MOVING_SPEED && st.peak_rearm) begin
                        st.peak_rearm = 1'b0;
                        st.peak_speed = spd;
                    end

                    // zero-to-target timer
                    if (spd <= spdtmr_pkg::STOP_SPEED) begin
                        st.timer_phase = spdtmr_pkg::PH_IDLE;
                    end
                    if (spd > spdtmr_pkg::STOP_SPEED && spd < cfg.target_speed &&
                        st.timer_phase == spdtmr_pkg::PH_IDLE) begin
                        st.run_start   = in_word.now_ms;
                        st.timer_phase = spdtmr_pkg::PH_RUN;
                    end
                    if (spd > spdtmr_pkg::MOVING_SPEED &&
                        st.timer_phase == spdtmr_pkg::PH_RUN) begin
                        st.run_elapsed = in_word.now_ms - st.run_start;
                    end
                    if (spd >= cfg.target_speed &&
                        st.timer_phase == spdtmr_pkg::PH_RUN) begin
                        st.timer_phase  = spdtmr_pkg::PH_DONE;
                        st.previous_run = st.run_elapsed;
                        finished        = 1'b1;
                    end
                    // timeout restores the last run time
                    if (st.run_elapsed > cfg.run_timeout_ms) begin
                        st.run_elapsed = st.previous_run;
                        st.timer_phase = spdtmr_pkg::PH_DONE;
                        timed_out      = 1'b1;
                    end
                end
            end else if (st.fix_held) begin
                // fix lost: restart fix timing
                st.fix_held         = 1'b0;
                st.fix_search_start = in_word.now_ms;
            end
        end
    end

    assign state_new = st;

    always_comb begin
        out_word.shown_speed     = st.held_speed;
        out_word.max_speed       = st.peak_speed;
        out_word.run_phase       = st.timer_phase;
        out_word.run_time_ms     = st.run_elapsed;
        out_word.last_run_ms     = st.previous_run;
        out_word.run_finished    = finished;
        out_word.run_timed_out   = timed_out;
        out_word.have_fix        = st.fix_held;
        out_word.fix_acquired    = acquired;
        out_word.fix_duration_ms = st.fix_time;
    end

endmodule

`default_nettype wire

// ----- design/speed_max_and_zero_to_target_timer_core.sv -----
// Speed display, peak speed, zero-to-target timer and time-to-first-fix tracker.
// Input channel s_valid/s_ready/s_data carries one receiver update per word;
// result channel m_valid/m_ready/m_data returns exactly one result word per update.
// Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_addr on the
// clock edge, no wait states; unused addresses are ignored. Write only while idle.
// Path: input register, result register, m_data. Throughput: one word per cycle
// while m_ready is high; the update is a single pass of compares and 32-bit
// subtracts between the input register and the result register, and the
// tracker state is written at the same edge that loads the result register.
// Stall: when m_ready is low the result register holds, the input register keeps
// one further word, and s_ready drops only once both are full.
// Reset (aresetn low, synchronous): both channels empty, tracker state cleared,
// timer idle, configuration back to its defaults (block disabled).
`default_nettype none

module speed_max_and_zero_to_target_timer_core (
    input  var logic                                   aclk,
    input  var logic                                   aresetn,
    // configuration
    input  var logic                                   cfg_wr_en,
    input  var logic [spdtmr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  var logic [spdtmr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // updates in
    input  var logic                                   s_valid,
    output var logic                                   s_ready,
    input  var spdtmr_pkg::in_word_t                   s_data,
    // results out
    output var logic                                   m_valid,
    input  var logic                                   m_ready,
    output var spdtmr_pkg::out_word_t                  m_data
);

    spdtmr_pkg::cfg_t      cfg_reg;
    spdtmr_pkg::cfg_t      cfg_next;
    spdtmr_pkg::state_t    state_reg;
    spdtmr_pkg::state_t    state_next;
    spdtmr_pkg::in_word_t  in_word_reg;
    logic                  in_valid_reg;
    spdtmr_pkg::out_word_t out_word_reg;
    spdtmr_pkg::out_word_t out_word_next;
    logic                  out_valid_reg;
    logic                  advance;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                spdtmr_pkg::REG_BLOCK_ENABLED:  cfg_next.block_enabled  = cfg_wdata[0];
                spdtmr_pkg::REG_AGE_LIMIT_MS:   cfg_next.age_limit_ms   = cfg_wdata[15:0];
                spdtmr_pkg::REG_STOP_FLOOR:     cfg_next.stop_floor     = cfg_wdata[15:0];
                spdtmr_pkg::REG_HDOP_LIMIT:     cfg_next.hdop_limit     = cfg_wdata[13:0];
                spdtmr_pkg::REG_SPEED_CEILING:  cfg_next.speed_ceiling  = cfg_wdata[15:0];
                spdtmr_pkg::REG_TARGET_SPEED:   cfg_next.target_speed   = cfg_wdata[15:0];
                spdtmr_pkg::REG_RUN_TIMEOUT_MS: cfg_next.run_timeout_ms = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= spdtmr_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // update logic
    spdtmr_update u_update (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .in_word   (in_word_reg),
        .state_new (state_next),
        .out_word  (out_word_next)
    );

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spdtmr_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // checks
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("tracker state changed without an update");

    a_acquire_has_fix: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fix_acquired) |-> m_data.have_fix)
        else $error("fix acquired pulse without fix held");

    a_timeout_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.run_timed_out) |-> (m_data.run_phase == spdtmr_pkg::PH_DONE))
        else $error("timeout without finished phase");

    a_disabled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !cfg_reg.block_enabled) |->
        !(m_data.run_finished || m_data.run_timed_out || m_data.fix_acquired))
        else $error("event pulse while block disabled");

endmodule

`default_nettype wire
